// ===== hw/rtl/tilt_complementary_filter_unit_defines.svh =====
// Assertion macros shared by the tilt complementary filter RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef TILT_COMPLEMENTARY_FILTER_UNIT_DEFINES_SVH
`define TILT_COMPLEMENTARY_FILTER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TCF_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tilt filter check failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define TCF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tilt filter check failed in the next cycle");

`endif

// ===== hw/rtl/tcf_pkg.sv =====
// Package for the tilt complementary filter: widths, constants, types and tables.
// No dependencies; used by every module of the block.
`default_nettype none

package tcf_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_LEN     = 24;
    localparam int CORDIC_ITERS = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;
    localparam int STEP_W       = $clog2(ATAN_LEN);

    localparam int SAMPLE_W   = 16;
    localparam int ANGLE_W    = 32;
    localparam int GAIN_W     = 16;
    localparam int WEIGHT_W   = 17;
    localparam int MAG_W      = 17;
    localparam int XY_W       = 20;
    localparam int Z_W        = 26;
    localparam int ATAN_W     = 22;
    localparam int MUL_A_W    = 18;
    localparam int PROD_W     = 50;
    localparam int ACC_W      = 52;
    localparam int FRAC_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    localparam logic [WEIGHT_W-1:0]   WEIGHT_ONE     = 17'd65536;
    localparam logic signed [Z_W-1:0] DEG180         = 26'sd11796480;
    localparam logic signed [ACC_W-1:0] ROUND_HALF   = 52'sd32768;
    localparam logic [STEP_W-1:0]     ITER_LAST      = STEP_W'(CORDIC_ITERS - 1);

    localparam logic [GAIN_W-1:0]   GAIN_RESET     = 16'd10;
    localparam logic [WEIGHT_W-1:0] ALPHA_RESET    = 17'd64225;
    localparam logic [MAG_W-1:0]    MAG_LOW_RESET  = 17'd8192;
    localparam logic [MAG_W-1:0]    MAG_HIGH_RESET = 17'd32768;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GYRO_GAIN,
        CFG_BLEND_ALPHA,
        CFG_MAG_LOW,
        CFG_MAG_HIGH
    } cfg_idx_t;

    typedef enum logic [1:0] {
        MUL_GYRO_X,
        MUL_GYRO_Y,
        MUL_ALPHA_ANGLE,
        MUL_BETA_ACC
    } mul_op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_GYRO_P,
        S_GYRO_R,
        S_GYRO_W,
        S_CINIT,
        S_CITER,
        S_BLEND_A,
        S_BLEND_B,
        S_BLEND_C,
        S_OUT
    } tcf_state_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] accel_x;
        logic signed [SAMPLE_W-1:0] accel_y;
        logic signed [SAMPLE_W-1:0] accel_z;
        logic signed [SAMPLE_W-1:0] gyro_x;
        logic signed [SAMPLE_W-1:0] gyro_y;
    } tcf_in_t;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] pitch_deg;
        logic signed [ANGLE_W-1:0] roll_deg;
        logic                      accel_used;
    } tcf_out_t;

    typedef struct packed {
        logic              load_sample;
        logic              load_used;
        logic              mul_en;
        mul_op_t           mul_op;
        logic              gyro_pitch;
        logic              gyro_roll;
        logic              cordic_init;
        logic              cordic_step;
        logic [STEP_W-1:0] step_idx;
        logic              axis_roll;
        logic              sum_load;
        logic              blend_write;
        logic              load_out;
    } tcf_cmd_t;

    typedef struct packed {
        logic used;
        logic out_free;
    } tcf_status_t;

    // Arctangent of 2^-i in degrees, Q16.16, rounded to nearest.
    function automatic logic [ATAN_W-1:0] atan_entry(input logic [STEP_W-1:0] idx);
        logic [ATAN_W-1:0] v;
        case (idx)
            5'd0:    v = 22'd2949120;
            5'd1:    v = 22'd1740967;
            5'd2:    v = 22'd919879;
            5'd3:    v = 22'd466945;
            5'd4:    v = 22'd234379;
            5'd5:    v = 22'd117304;
            5'd6:    v = 22'd58666;
            5'd7:    v = 22'd29335;
            5'd8:    v = 22'd14668;
            5'd9:    v = 22'd7334;
            5'd10:   v = 22'd3667;
            5'd11:   v = 22'd1833;
            5'd12:   v = 22'd917;
            5'd13:   v = 22'd458;
            5'd14:   v = 22'd229;
            5'd15:   v = 22'd115;
            5'd16:   v = 22'd57;
            5'd17:   v = 22'd29;
            5'd18:   v = 22'd14;
            5'd19:   v = 22'd7;
            5'd20:   v = 22'd4;
            5'd21:   v = 22'd2;
            5'd22:   v = 22'd1;
            default: v = '0;
        endcase
        return v;
    endfunction

    // Saturates a wide signed value to the signed 32-bit angle range.
    function automatic logic signed [ANGLE_W-1:0] sat_angle(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] max_v;
        logic signed [ACC_W-1:0] min_v;
        logic signed [ANGLE_W-1:0] r;
        max_v = {{(ACC_W-ANGLE_W+1){1'b0}}, {(ANGLE_W-1){1'b1}}};
        min_v = {{(ACC_W-ANGLE_W+1){1'b1}}, {(ANGLE_W-1){1'b0}}};
        if (v > max_v) begin
            r = {1'b0, {(ANGLE_W-1){1'b1}}};
        end else if (v < min_v) begin
            r = {1'b1, {(ANGLE_W-1){1'b0}}};
        end else begin
            r = v[ANGLE_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/tcf_ctrl.sv =====
// Controller state machine of the tilt complementary filter.
// Depends on tcf_pkg and the assertion macro header.
`default_nettype none
`include "tilt_complementary_filter_unit_defines.svh"

module tcf_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire tcf_pkg::tcf_status_t status,
    output tcf_pkg::tcf_cmd_t        cmd
);
    import tcf_pkg::*;

    tcf_state_t        state_reg, state_next;
    logic [STEP_W-1:0] iter_reg, iter_next;
    logic              axis_reg, axis_next;
    logic              accept;

    assign s_ready = (state_reg == S_IDLE);
    assign accept  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            iter_reg  <= '0;
            axis_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            iter_reg  <= iter_next;
            axis_reg  <= axis_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        iter_next  = iter_reg;
        axis_next  = axis_reg;
        unique case (state_reg)
            S_IDLE: begin
                axis_next = 1'b0;
                if (accept) begin
                    state_next = S_GYRO_P;
                end
            end
            S_GYRO_P:  state_next = S_GYRO_R;
            S_GYRO_R:  state_next = S_GYRO_W;
            S_GYRO_W:  state_next = status.used ? S_CINIT : S_OUT;
            S_CINIT: begin
                iter_next  = '0;
                state_next = S_CITER;
            end
            S_CITER: begin
                iter_next = iter_reg + 1'b1;
                if (iter_reg == ITER_LAST) begin
                    state_next = S_BLEND_A;
                end
            end
            S_BLEND_A: state_next = S_BLEND_B;
            S_BLEND_B: state_next = S_BLEND_C;
            S_BLEND_C: begin
                if (axis_reg) begin
                    state_next = S_OUT;
                end else begin
                    axis_next  = 1'b1;
                    state_next = S_CINIT;
                end
            end
            S_OUT: begin
                if (status.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default:   state_next = S_IDLE;
        endcase
    end

    always_comb begin
        cmd             = '0;
        cmd.mul_op      = MUL_GYRO_X;
        cmd.step_idx    = iter_reg;
        cmd.axis_roll   = axis_reg;
        cmd.load_sample = accept;
        unique case (state_reg)
            S_IDLE: ;
            S_GYRO_P: begin
                cmd.mul_en    = 1'b1;
                cmd.mul_op    = MUL_GYRO_X;
                cmd.load_used = 1'b1;
            end
            S_GYRO_R: begin
                cmd.gyro_pitch = 1'b1;
                cmd.mul_en     = 1'b1;
                cmd.mul_op     = MUL_GYRO_Y;
            end
            S_GYRO_W:  cmd.gyro_roll = 1'b1;
            S_CINIT:   cmd.cordic_init = 1'b1;
            S_CITER:   cmd.cordic_step = 1'b1;
            S_BLEND_A: begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = MUL_ALPHA_ANGLE;
            end
            S_BLEND_B: begin
                cmd.sum_load = 1'b1;
                cmd.mul_en   = 1'b1;
                cmd.mul_op   = MUL_BETA_ACC;
            end
            S_BLEND_C: cmd.blend_write = 1'b1;
            S_OUT:     cmd.load_out = status.out_free;
            default: ;
        endcase
    end

    `TCF_ASSERT_NEXT(a_iter_done, aclk, aresetn, state_reg == S_CITER && iter_reg == ITER_LAST, state_reg == S_BLEND_A)
    `TCF_ASSERT_NEXT(a_no_correction, aclk, aresetn, state_reg == S_GYRO_W && !status.used, state_reg == S_OUT)
    `TCF_ASSERT_SAME(a_out_free, aclk, aresetn, cmd.load_out, status.out_free)
    `TCF_ASSERT_NEXT(a_roll_last, aclk, aresetn, state_reg == S_BLEND_C && !axis_reg, state_reg == S_CINIT && axis_reg)

endmodule

`default_nettype wire

// ===== hw/rtl/tcf_dp.sv =====
// Datapath of the tilt complementary filter: configuration, angles, multiplier,
// CORDIC iteration and the output register. Depends on tcf_pkg.
`default_nettype none

module tcf_dp (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire tcf_pkg::tcf_in_t                    s_data,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output tcf_pkg::tcf_out_t                        m_data,
    input  wire logic                                cfg_wr_en,
    input  wire logic [tcf_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [tcf_pkg::CFG_DATA_W-1:0]      cfg_wr_data,
    input  wire tcf_pkg::tcf_cmd_t                   cmd,
    output tcf_pkg::tcf_status_t                     status
);
    import tcf_pkg::*;

    logic [GAIN_W-1:0]   gain_reg;
    logic [WEIGHT_W-1:0] alpha_reg;
    logic [MAG_W-1:0]    mag_low_reg;
    logic [MAG_W-1:0]    mag_high_reg;

    tcf_in_t                    sample_reg;
    logic signed [ANGLE_W-1:0]  pitch_reg, pitch_next;
    logic signed [ANGLE_W-1:0]  roll_reg, roll_next;
    logic                       used_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [PROD_W-1:0]   sum_reg;
    logic signed [XY_W-1:0]     cx_reg, cx_next;
    logic signed [XY_W-1:0]     cy_reg, cy_next;
    logic signed [Z_W-1:0]      cz_reg, cz_next;
    logic                       skip_reg, skip_next;
    tcf_out_t                   out_reg;
    logic                       m_valid_reg;

    logic [WEIGHT_W-1:0]        alpha_c;
    logic [WEIGHT_W-1:0]        beta;
    logic signed [MUL_A_W-1:0]  mul_a;
    logic signed [ANGLE_W-1:0]  mul_b;
    logic signed [PROD_W-1:0]   product;
    logic signed [SAMPLE_W:0]   ax_e, ay_e, az_e;
    logic [MAG_W-1:0]           mag;
    logic signed [ACC_W-1:0]    gyro_p_sum, gyro_r_sum, blend_sum, blend_shift;
    logic signed [ANGLE_W-1:0]  blended;
    logic signed [SAMPLE_W-1:0] num;
    logic signed [XY_W-1:0]     num_e, den_e, sx, sy;
    logic signed [Z_W-1:0]      atan_z;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg     <= GAIN_RESET;
            alpha_reg    <= ALPHA_RESET;
            mag_low_reg  <= MAG_LOW_RESET;
            mag_high_reg <= MAG_HIGH_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_GYRO_GAIN:   gain_reg     <= cfg_wr_data[GAIN_W-1:0];
                CFG_BLEND_ALPHA: alpha_reg    <= cfg_wr_data[WEIGHT_W-1:0];
                CFG_MAG_LOW:     mag_low_reg  <= cfg_wr_data[MAG_W-1:0];
                CFG_MAG_HIGH:    mag_high_reg <= cfg_wr_data[MAG_W-1:0];
                default: ;
            endcase
        end
    end

    assign alpha_c = (alpha_reg > WEIGHT_ONE) ? WEIGHT_ONE : alpha_reg;
    assign beta    = WEIGHT_ONE - alpha_c;

    always_comb begin
        case (cmd.mul_op)
            MUL_GYRO_X: begin
                mul_a = MUL_A_W'(sample_reg.gyro_x);
                mul_b = $signed({{(ANGLE_W-GAIN_W){1'b0}}, gain_reg});
            end
            MUL_GYRO_Y: begin
                mul_a = MUL_A_W'(sample_reg.gyro_y);
                mul_b = $signed({{(ANGLE_W-GAIN_W){1'b0}}, gain_reg});
            end
            MUL_ALPHA_ANGLE: begin
                mul_a = $signed({{(MUL_A_W-WEIGHT_W){1'b0}}, alpha_c});
                mul_b = cmd.axis_roll ? roll_reg : pitch_reg;
            end
            default: begin
                mul_a = $signed({{(MUL_A_W-WEIGHT_W){1'b0}}, beta});
                mul_b = ANGLE_W'(cz_reg);
            end
        endcase
    end

    assign product = PROD_W'(mul_a) * PROD_W'(mul_b);

    assign ax_e = (SAMPLE_W+1)'(sample_reg.accel_x);
    assign ay_e = (SAMPLE_W+1)'(sample_reg.accel_y);
    assign az_e = (SAMPLE_W+1)'(sample_reg.accel_z);
    assign mag  = (ax_e < 0 ? MAG_W'(-ax_e) : MAG_W'(ax_e))
                + (ay_e < 0 ? MAG_W'(-ay_e) : MAG_W'(ay_e))
                + (az_e < 0 ? MAG_W'(-az_e) : MAG_W'(az_e));

    assign gyro_p_sum  = ACC_W'(pitch_reg) + ACC_W'(prod_reg);
    assign gyro_r_sum  = ACC_W'(roll_reg) - ACC_W'(prod_reg);
    assign blend_sum   = ACC_W'(sum_reg) + ACC_W'(prod_reg) + ROUND_HALF;
    assign blend_shift = blend_sum >>> FRAC_W;
    assign blended     = sat_angle(blend_shift);

    always_comb begin
        pitch_next = pitch_reg;
        roll_next  = roll_reg;
        if (cmd.gyro_pitch) begin
            pitch_next = sat_angle(gyro_p_sum);
        end
        if (cmd.gyro_roll) begin
            roll_next = sat_angle(gyro_r_sum);
        end
        if (cmd.blend_write) begin
            if (cmd.axis_roll) begin
                roll_next = blended;
            end else begin
                pitch_next = blended;
            end
        end
    end

    assign num    = cmd.axis_roll ? sample_reg.accel_x : sample_reg.accel_y;
    assign num_e  = XY_W'(num);
    assign den_e  = XY_W'(sample_reg.accel_z);
    assign sx     = cx_reg >>> cmd.step_idx;
    assign sy     = cy_reg >>> cmd.step_idx;
    assign atan_z = $signed({{(Z_W-ATAN_W){1'b0}}, atan_entry(cmd.step_idx)});

    always_comb begin
        cx_next   = cx_reg;
        cy_next   = cy_reg;
        cz_next   = cz_reg;
        skip_next = skip_reg;
        if (cmd.cordic_init) begin
            if (num == 0) begin
                skip_next = 1'b1;
                cz_next   = (den_e < 0) ? DEG180 : '0;
            end else if (den_e < 0) begin
                skip_next = 1'b0;
                cx_next   = -den_e;
                cy_next   = -num_e;
                cz_next   = (num_e >= 0) ? DEG180 : -DEG180;
            end else begin
                skip_next = 1'b0;
                cx_next   = den_e;
                cy_next   = num_e;
                cz_next   = '0;
            end
        end else if (cmd.cordic_step && !skip_reg) begin
            if (cy_reg > 0) begin
                cx_next = cx_reg + sy;
                cy_next = cy_reg - sx;
                cz_next = cz_reg + atan_z;
            end else begin
                cx_next = cx_reg - sy;
                cy_next = cy_reg + sx;
                cz_next = cz_reg - atan_z;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pitch_reg   <= '0;
            roll_reg    <= '0;
            used_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            pitch_reg <= pitch_next;
            roll_reg  <= roll_next;
            if (cmd.load_used) begin
                used_reg <= (mag > mag_low_reg) && (mag < mag_high_reg);
            end
            if (cmd.load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_sample) begin
            sample_reg <= s_data;
        end
        if (cmd.mul_en) begin
            prod_reg <= product;
        end
        if (cmd.sum_load) begin
            sum_reg <= prod_reg;
        end
        cx_reg   <= cx_next;
        cy_reg   <= cy_next;
        cz_reg   <= cz_next;
        skip_reg <= skip_next;
        if (cmd.load_out) begin
            out_reg.pitch_deg  <= pitch_reg;
            out_reg.roll_deg   <= roll_reg;
            out_reg.accel_used <= used_reg;
        end
    end

    assign status.used     = used_reg;
    assign status.out_free = !m_valid_reg || m_ready;
    assign m_valid         = m_valid_reg;
    assign m_data          = out_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/tilt_complementary_filter_unit.sv =====
// Top level of the tilt complementary filter: controller and datapath joined.
// Depends on tcf_pkg, tcf_ctrl and tcf_dp.
`default_nettype none

// Each beat on s_ carries one raw IMU sample; pitch and roll (degrees, Q16.16)
// are updated from the gyro rates and, when the accelerometer magnitude sum lies
// strictly between the two limits, blended with CORDIC atan2 angles. One result
// beat leaves on m_ for every input beat. The block works on one sample at a time:
// a sample without correction skips the CORDIC, and a corrected one runs the
// single shared CORDIC stage and the shared multiplier once per axis. The
// result sits in an output register, so the next sample is taken while it waits.
// The user writes configuration through cfg_wr_en, cfg_index and cfg_wr_data
// only while idle; the block itself does not enforce this.

module tilt_complementary_filter_unit (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire tcf_pkg::tcf_in_t                s_data,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output tcf_pkg::tcf_out_t                    m_data,
    input  wire logic                            cfg_wr_en,
    input  wire logic [tcf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [tcf_pkg::CFG_DATA_W-1:0]  cfg_wr_data
);
    import tcf_pkg::*;

    tcf_cmd_t    cmd;
    tcf_status_t status;

    tcf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    tcf_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .status      (status)
    );

endmodule

`default_nettype wire

// ===== bench/tb_tilt_complementary_filter_unit.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the tilt complementary filter: random and directed IMU samples,
// register settings and handshake stalls, with every result beat checked against a predictor.
// Depends on tcf_pkg and tilt_complementary_filter_unit.

module tb_tilt_complementary_filter_unit;

    import tcf_pkg::*;

    localparam int  CORDIC_PASSES = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
    localparam longint ANGLE_180  = 64'sd11796480;
    localparam longint ANGLE_MAX  = 64'sd2147483647;
    localparam longint ANGLE_MIN  = -64'sd2147483648;
    localparam int  HOLD_CYCLES   = 300;
    localparam int  STALL_LIMIT   = 4000;
    localparam int  SETTLE_CYCLES = 8;
    localparam int  TAIL_CYCLES   = 60;
    localparam int  PRINT_CAP     = 40;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    tcf_in_t   s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    tcf_out_t  m_data;
    logic      cfg_wr_en = 1'b0;
    cfg_idx_t  cfg_index = CFG_GYRO_GAIN;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;

    longint gain_reg;
    longint alpha_reg;
    longint low_reg;
    longint high_reg;
    longint pitch_model;
    longint roll_model;

    tcf_out_t pending_attitude[$];
    int       gap_pct = 13;
    logic     hold_request = 1'b0;
    int       hold_left = 0;
    int       stall_count = 0;
    int       mismatch_count = 0;
    int       result_beats = 0;

    tilt_complementary_filter_unit DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic longint atan_step_deg(input int i);
        longint v;
        case (i)
            0:       v = 2949120;
            1:       v = 1740967;
            2:       v = 919879;
            3:       v = 466945;
            4:       v = 234379;
            5:       v = 117304;
            6:       v = 58666;
            7:       v = 29335;
            8:       v = 14668;
            9:       v = 7334;
            10:      v = 3667;
            11:      v = 1833;
            12:      v = 917;
            13:      v = 458;
            14:      v = 229;
            15:      v = 115;
            16:      v = 57;
            17:      v = 29;
            18:      v = 14;
            19:      v = 7;
            20:      v = 4;
            21:      v = 2;
            22:      v = 1;
            default: v = 0;
        endcase
        return v;
    endfunction

    function automatic longint clamp_angle(input longint v);
        longint r;
        r = v;
        if (v > ANGLE_MAX) begin
            r = ANGLE_MAX;
        end else if (v < ANGLE_MIN) begin
            r = ANGLE_MIN;
        end
        return r;
    endfunction

    // Vectoring CORDIC; arithmetic shifts of signed values round towards minus infinity.
    function automatic longint cordic_atan2_deg(input longint num, input longint den);
        longint x;
        longint y;
        longint z;
        longint xn;
        int     i;
        if (num == 0) begin
            return (den < 0) ? ANGLE_180 : 0;
        end
        x = den;
        y = num;
        z = 0;
        if (den < 0) begin
            z = (num >= 0) ? ANGLE_180 : -ANGLE_180;
            x = -den;
            y = -num;
        end
        for (i = 0; i < CORDIC_PASSES; i++) begin
            if (y > 0) begin
                xn = x + (y >>> i);
                y  = y - (x >>> i);
                z  = z + atan_step_deg(i);
            end else begin
                xn = x - (y >>> i);
                y  = y + (x >>> i);
                z  = z - atan_step_deg(i);
            end
            x = xn;
        end
        return z;
    endfunction

    function automatic longint blend_angle(input longint angle, input longint acc_angle,
                                           input longint w);
        longint s;
        s = w * angle + (65536 - w) * acc_angle + 32768;
        return clamp_angle(s >>> 16);
    endfunction

    function automatic tcf_out_t predict_attitude(input tcf_in_t smp);
        longint   ax;
        longint   ay;
        longint   az;
        longint   gx;
        longint   gy;
        longint   mag;
        longint   w;
        tcf_out_t res;
        ax = longint'($signed(smp.accel_x));
        ay = longint'($signed(smp.accel_y));
        az = longint'($signed(smp.accel_z));
        gx = longint'($signed(smp.gyro_x));
        gy = longint'($signed(smp.gyro_y));
        pitch_model = clamp_angle(pitch_model + gx * gain_reg);
        roll_model  = clamp_angle(roll_model - gy * gain_reg);
        mag = ((ax < 0) ? -ax : ax) + ((ay < 0) ? -ay : ay) + ((az < 0) ? -az : az);
        res.accel_used = 1'b0;
        if (mag > low_reg && mag < high_reg) begin
            w = (alpha_reg > 65536) ? 65536 : alpha_reg;
            pitch_model = blend_angle(pitch_model, cordic_atan2_deg(ay, az), w);
            roll_model  = blend_angle(roll_model, cordic_atan2_deg(ax, az), w);
            res.accel_used = 1'b1;
        end
        res.pitch_deg = 32'(pitch_model);
        res.roll_deg  = 32'(roll_model);
        return res;
    endfunction

    function automatic tcf_in_t make_sample(input int ax, input int ay, input int az,
                                            input int gx, input int gy);
        tcf_in_t smp;
        smp.accel_x = 16'(ax);
        smp.accel_y = 16'(ay);
        smp.accel_z = 16'(az);
        smp.gyro_x  = 16'(gx);
        smp.gyro_y  = 16'(gy);
        return smp;
    endfunction

    function automatic logic [15:0] extreme_count();
        logic [15:0] v;
        case ($urandom_range(4))
            0:       v = 16'h8000;
            1:       v = 16'hFFFF;
            2:       v = 16'h0000;
            3:       v = 16'h0001;
            default: v = 16'h7FFF;
        endcase
        return v;
    endfunction

    function automatic logic [15:0] scaled_count(input int span);
        int v;
        v = ($urandom_range(9) == 0) ? 0 : $urandom_range(0, span);
        if ($urandom_range(1) == 1) begin
            v = -v;
        end
        return 16'(v);
    endfunction

    // Most samples are aimed at the correction window; the rest cover the full range.
    function automatic tcf_in_t random_sample();
        tcf_in_t smp;
        int      span;
        int      pick;
        span = (high_reg > 3) ? int'(high_reg / 3) : 20000;
        if (span > 32767) begin
            span = 32767;
        end
        pick = $urandom_range(99);
        if (pick < 25) begin
            smp.accel_x = 16'($urandom);
            smp.accel_y = 16'($urandom);
            smp.accel_z = 16'($urandom);
        end else if (pick < 30) begin
            smp.accel_x = extreme_count();
            smp.accel_y = extreme_count();
            smp.accel_z = extreme_count();
        end else begin
            smp.accel_x = scaled_count(span);
            smp.accel_y = scaled_count(span);
            smp.accel_z = scaled_count(span);
        end
        pick = $urandom_range(99);
        if (pick < 70) begin
            smp.gyro_x = scaled_count(256);
            smp.gyro_y = scaled_count(256);
        end else if (pick < 90) begin
            smp.gyro_x = 16'($urandom);
            smp.gyro_y = 16'($urandom);
        end else begin
            smp.gyro_x = extreme_count();
            smp.gyro_y = extreme_count();
        end
        return smp;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (mismatch_count < PRINT_CAP) begin
            $display("%0t: result beat %0d, %s: got %0d, expected %0d",
                     $time, result_beats, what, got, want);
        end
        mismatch_count++;
    endtask

    task automatic check_attitude(input tcf_out_t got);
        tcf_out_t want;
        if (pending_attitude.size() == 0) begin
            report_mismatch("beat with nothing expected", got.pitch_deg, 0);
            return;
        end
        want = pending_attitude.pop_front();
        if (got.pitch_deg !== want.pitch_deg) begin
            report_mismatch("pitch_deg", got.pitch_deg, want.pitch_deg);
        end
        if (got.roll_deg !== want.roll_deg) begin
            report_mismatch("roll_deg", got.roll_deg, want.roll_deg);
        end
        if (got.accel_used !== want.accel_used) begin
            report_mismatch("accel_used", got.accel_used, want.accel_used);
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            check_attitude(m_data);
            result_beats++;
        end
    end

    always @(posedge aclk) begin
        if (hold_request) begin
            hold_left = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= gap_pct);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en) begin
            stall_count = 0;
        end else begin
            stall_count++;
        end
        if (stall_count >= STALL_LIMIT) begin
            $display("tilt_complementary_filter_unit: mismatch");
            $finish;
        end
    end

    task automatic send_sample(input tcf_in_t smp);
        while ($urandom_range(99) < gap_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= smp;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        pending_attitude.push_back(predict_attitude(smp));
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_attitude.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_config(input logic [15:0] gain, input logic [16:0] alpha,
                              input logic [16:0] lo, input logic [16:0] hi);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_index   <= CFG_GYRO_GAIN;
        cfg_wr_data <= {1'b0, gain};
        @(posedge aclk);
        cfg_index   <= CFG_BLEND_ALPHA;
        cfg_wr_data <= alpha;
        @(posedge aclk);
        cfg_index   <= CFG_MAG_LOW;
        cfg_wr_data <= lo;
        @(posedge aclk);
        cfg_index   <= CFG_MAG_HIGH;
        cfg_wr_data <= hi;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        gain_reg  = longint'(gain);
        alpha_reg = longint'(alpha);
        low_reg   = longint'(lo);
        high_reg  = longint'(hi);
    endtask

    // Reset settings: window edges, zero numerators and a negative Z axis.
    task automatic test_reset_defaults();
        send_sample(make_sample(0, 0, 0, 0, 0));
        send_sample(make_sample(32767, 32767, 32767, 32767, 32767));
        send_sample(make_sample(-32768, -32768, -32768, -32768, -32768));
        send_sample(make_sample(0, 0, 10000, 100, -50));
        send_sample(make_sample(0, 0, -10000, -20, 30));
        send_sample(make_sample(10000, 0, 0, 5, 5));
        send_sample(make_sample(-6000, 7000, -4000, 0, 0));
        send_sample(make_sample(8192, 0, 0, 1, -1));
        send_sample(make_sample(0, 8193, 0, -1, 1));
        send_sample(make_sample(16384, 0, 16384, 0, 0));
        send_sample(make_sample(16383, 0, 16384, 0, 0));
    endtask

    // Full gain with both limits at zero drives both angles into saturation.
    task automatic test_saturation();
        int i;
        set_config(16'd65535, 17'd65536, 17'd0, 17'd0);
        for (i = 0; i < 3; i++) begin
            send_sample(make_sample(3000, 2000, 5000, 32767, -32768));
        end
        for (i = 0; i < 4; i++) begin
            send_sample(make_sample(3000, 2000, 5000, -32768, 32767));
        end
    endtask

    // A weight above one acts as one; a zero weight takes the accelerometer angle alone.
    task automatic test_blend_weights();
        set_config(16'd500, 17'd131071, 17'd0, 17'd98304);
        send_sample(make_sample(3000, -2000, 5000, 1000, -1000));
        set_config(16'd500, 17'd0, 17'd0, 17'd98304);
        send_sample(make_sample(-3000, 2000, -5000, 1000, -1000));
        send_sample(make_sample(0, -1, 0, 0, 0));
    endtask

    task automatic test_random_settings();
        int i;
        int k;
        int lo;
        for (k = 0; k < 7; k++) begin
            case (k)
                0: set_config(16'd10, 17'd64225, 17'd8192, 17'd32768);
                1: set_config(16'd0, 17'd0, 17'd0, 17'd98304);
                2: set_config(16'd65535, 17'd65536, 17'd8192, 17'd32768);
                3: set_config(16'd300, 17'd131071, 17'd1000, 17'd40000);
                4: set_config(16'd1000, 17'd32768, 17'd98304, 17'd0);
                5: begin
                    lo = $urandom_range(0, 20000);
                    set_config(16'($urandom), 17'($urandom_range(0, 65536)), 17'(lo),
                               17'(lo + $urandom_range(1, 60000)));
                end
                default: set_config(16'd1, 17'd65535, 17'd40000, 17'd98304);
            endcase
            for (i = 0; i < 180; i++) begin
                send_sample(random_sample());
            end
        end
    endtask

    task automatic test_output_stall();
        int i;
        set_config(16'd10, 17'd64225, 17'd8192, 17'd32768);
        hold_request = 1'b1;
        for (i = 0; i < 40; i++) begin
            send_sample(random_sample());
        end
        drain_results();
    endtask

    task automatic test_back_to_back();
        int i;
        gap_pct = 0;
        for (i = 0; i < 250; i++) begin
            send_sample(random_sample());
        end
        drain_results();
        gap_pct = 13;
    endtask

    initial begin
        gain_reg    = 10;
        alpha_reg   = 64225;
        low_reg     = 8192;
        high_reg    = 32768;
        pitch_model = 0;
        roll_model  = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_defaults();
        test_saturation();
        test_blend_weights();
        test_random_settings();
        test_output_stall();
        test_back_to_back();
        drain_results();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && pending_attitude.size() == 0) begin
            $display("tilt_complementary_filter_unit: match");
        end else begin
            $display("tilt_complementary_filter_unit: mismatch");
        end
        $finish;
    end

endmodule
